[rtl/core/ufrc_pkg.sv]
`timescale 1ns / 1ps

package ufrc_pkg;

  typedef logic [7:0] elem_t;

  typedef enum logic {
    OP_FIND  = 1'b0,
    OP_UNION = 1'b1
  } op_t;

  localparam int RANK_W = 4;

  typedef logic [RANK_W-1:0] rank_t;

  localparam rank_t RANK_INIT = rank_t'(1);
  localparam rank_t RANK_MAX  = rank_t'(15);

endpackage

[rtl/core/ufrc_if.sv]
`timescale 1ns / 1ps

interface ufrc_in_if;
  logic             valid;
  logic             ready;
  ufrc_pkg::op_t    opcode;
  ufrc_pkg::elem_t  element_a;
  ufrc_pkg::elem_t  element_b;

  modport source (output valid, output opcode, output element_a, output element_b,
                  input ready);
  modport sink   (input valid, input opcode, input element_a, input element_b,
                  output ready);
endinterface

interface ufrc_out_if;
  logic             valid;
  logic             ready;
  ufrc_pkg::elem_t  set_root;
  logic             already_joined;

  modport source (output valid, output set_root, output already_joined, input ready);
  modport sink   (input valid, input set_root, input already_joined, output ready);
endinterface

[rtl/core/ufrc_fold.sv]
`timescale 1ns / 1ps

module ufrc_fold #(
  parameter int SET_COUNT = 256
) (
  input  ufrc_pkg::elem_t                 value_in,
  output logic [$clog2(SET_COUNT)-1:0]    index_out
);

  localparam int IDX_W = $clog2(SET_COUNT);
  localparam int REM_W = 24;

  logic [REM_W-1:0] rem;

  // Restoring reduction: one conditional subtract per bit of the 8-bit input.
  always_comb begin
    rem = REM_W'(value_in);
    for (int k = 7; k >= 0; k--) begin
      if (rem >= (REM_W'(SET_COUNT) << k)) begin
        rem = rem - (REM_W'(SET_COUNT) << k);
      end
    end
  end

  assign index_out = IDX_W'(rem);

endmodule

[rtl/core/union_find_rank_compress.sv]
`timescale 1ns / 1ps

// Channel  Dir  Beat contents                        Handshake
// in_ch    in   opcode, element_a, element_b         valid / ready
// out_ch   out  set_root, already_joined             valid / ready
//
// After reset a clearing pass initializes both tables; no beat is taken. A find walks the
// parent table from the element up to its root, walks the path again to point each node at
// the root, then loads the result register. A union runs two finds and, when the roots differ,
// reads both ranks. The single parent-table read port, one access per cycle, paces the walks.
// A result waits in the output register; a new beat is taken once the result is loaded there.

module union_find_rank_compress #(
  parameter int SET_COUNT = 256
) (
  input logic        clk,
  input logic        rst_n,
  ufrc_in_if.sink    in_ch,
  ufrc_out_if.source out_ch
);

  localparam int IDX_W = $clog2(SET_COUNT);

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK_START,
    S_WALK,
    S_COMP,
    S_RANK_A,
    S_RANK_B,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  idx_t clr_cnt_r, clr_cnt_nxt;
  idx_t cur_r, cur_nxt;
  idx_t start_r, start_nxt;
  idx_t elem_b_r, elem_b_nxt;
  ufrc_pkg::op_t op_r, op_nxt;
  logic phase_r, phase_nxt;
  idx_t ra_r, ra_nxt;
  idx_t root_r, root_nxt;
  ufrc_pkg::rank_t rank_a_r, rank_a_nxt;
  idx_t res_root_r, res_root_nxt;
  logic res_joined_r, res_joined_nxt;
  logic out_valid_r, out_valid_nxt;
  ufrc_pkg::elem_t out_root_r, out_root_nxt;
  logic out_joined_r, out_joined_nxt;

  idx_t parent_mem [SET_COUNT];
  ufrc_pkg::rank_t rank_mem [SET_COUNT];
  idx_t par_rd_r;
  ufrc_pkg::rank_t rank_rd_r;

  idx_t par_rd_addr, par_wr_addr, par_wr_data;
  logic par_we;
  idx_t rank_rd_addr, rank_wr_addr;
  ufrc_pkg::rank_t rank_wr_data;
  logic rank_we;

  idx_t fold_a, fold_b;
  logic in_fire, out_fire;

  ufrc_fold #(.SET_COUNT(SET_COUNT)) u_fold_a (
    .value_in  (in_ch.element_a),
    .index_out (fold_a)
  );

  ufrc_fold #(.SET_COUNT(SET_COUNT)) u_fold_b (
    .value_in  (in_ch.element_b),
    .index_out (fold_b)
  );

  assign in_ch.ready           = (state_r == S_IDLE);
  assign in_fire               = in_ch.valid && in_ch.ready;
  assign out_fire              = out_valid_r && out_ch.ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.set_root       = out_root_r;
  assign out_ch.already_joined = out_joined_r;

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    cur_nxt        = cur_r;
    start_nxt      = start_r;
    elem_b_nxt     = elem_b_r;
    op_nxt         = op_r;
    phase_nxt      = phase_r;
    ra_nxt         = ra_r;
    root_nxt       = root_r;
    rank_a_nxt     = rank_a_r;
    res_root_nxt   = res_root_r;
    res_joined_nxt = res_joined_r;
    out_valid_nxt  = out_valid_r;
    out_root_nxt   = out_root_r;
    out_joined_nxt = out_joined_r;
    par_rd_addr    = cur_r;
    par_we         = 1'b0;
    par_wr_addr    = cur_r;
    par_wr_data    = root_r;
    rank_rd_addr   = ra_r;
    rank_we        = 1'b0;
    rank_wr_addr   = ra_r;
    rank_wr_data   = rank_a_r;

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        par_we       = 1'b1;
        par_wr_addr  = clr_cnt_r;
        par_wr_data  = clr_cnt_r;
        rank_we      = 1'b1;
        rank_wr_addr = clr_cnt_r;
        rank_wr_data = ufrc_pkg::RANK_INIT;
        clr_cnt_nxt  = clr_cnt_r + idx_t'(1);
        if (clr_cnt_r == idx_t'(SET_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          op_nxt     = in_ch.opcode;
          start_nxt  = fold_a;
          cur_nxt    = fold_a;
          elem_b_nxt = fold_b;
          phase_nxt  = 1'b0;
          state_nxt  = S_WALK_START;
        end
      end
      S_WALK_START: begin
        par_rd_addr = cur_r;
        state_nxt   = S_WALK;
      end
      S_WALK: begin
        if (par_rd_r == cur_r) begin
          root_nxt    = cur_r;
          cur_nxt     = start_r;
          par_rd_addr = start_r;
          state_nxt   = S_COMP;
        end else begin
          cur_nxt     = par_rd_r;
          par_rd_addr = par_rd_r;
        end
      end
      S_COMP: begin
        if (cur_r != root_r) begin
          par_we      = 1'b1;
          par_wr_addr = cur_r;
          par_wr_data = root_r;
          cur_nxt     = par_rd_r;
          par_rd_addr = par_rd_r;
        end else if (!phase_r) begin
          if (op_r == ufrc_pkg::OP_FIND) begin
            res_root_nxt   = root_r;
            res_joined_nxt = 1'b0;
            state_nxt      = S_DONE;
          end else begin
            ra_nxt    = root_r;
            phase_nxt = 1'b1;
            start_nxt = elem_b_r;
            cur_nxt   = elem_b_r;
            state_nxt = S_WALK_START;
          end
        end else if (root_r == ra_r) begin
          res_root_nxt   = ra_r;
          res_joined_nxt = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          rank_rd_addr = ra_r;
          state_nxt    = S_RANK_A;
        end
      end
      S_RANK_A: begin
        rank_a_nxt   = rank_rd_r;
        rank_rd_addr = root_r;
        state_nxt    = S_RANK_B;
      end
      S_RANK_B: begin
        par_we         = 1'b1;
        res_joined_nxt = 1'b0;
        state_nxt      = S_DONE;
        if (rank_a_r == rank_rd_r) begin
          par_wr_addr  = root_r;
          par_wr_data  = ra_r;
          res_root_nxt = ra_r;
          if (rank_a_r != ufrc_pkg::RANK_MAX) begin
            rank_we      = 1'b1;
            rank_wr_addr = ra_r;
            rank_wr_data = rank_a_r + ufrc_pkg::rank_t'(1);
          end
        end else if (rank_a_r < rank_rd_r) begin
          par_wr_addr  = ra_r;
          par_wr_data  = root_r;
          res_root_nxt = root_r;
        end else begin
          par_wr_addr  = root_r;
          par_wr_data  = ra_r;
          res_root_nxt = ra_r;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_root_nxt   = ufrc_pkg::elem_t'(res_root_r);
          out_joined_nxt = res_joined_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r        <= cur_nxt;
    start_r      <= start_nxt;
    elem_b_r     <= elem_b_nxt;
    op_r         <= op_nxt;
    phase_r      <= phase_nxt;
    ra_r         <= ra_nxt;
    root_r       <= root_nxt;
    rank_a_r     <= rank_a_nxt;
    res_root_r   <= res_root_nxt;
    res_joined_r <= res_joined_nxt;
    out_root_r   <= out_root_nxt;
    out_joined_r <= out_joined_nxt;
  end

  always_ff @(posedge clk) begin
    if (par_we) begin
      parent_mem[par_wr_addr] <= par_wr_data;
    end
    par_rd_r <= parent_mem[par_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[rank_wr_addr] <= rank_wr_data;
    end
    rank_rd_r <= rank_mem[rank_rd_addr];
  end

  // Outside the clearing pass, no node is ever made its own parent.
  a_no_self_link: assert property (@(posedge clk) disable iff (!rst_n)
    (par_we && state_r != S_CLEAR) |-> (par_wr_data != par_wr_addr))
    else $error("parent write creates a self link");

  // A rank update only ever raises the stored rank.
  a_rank_rises: assert property (@(posedge clk) disable iff (!rst_n)
    (rank_we && state_r != S_CLEAR) |-> (rank_wr_data > rank_a_r))
    else $error("rank update does not raise the rank");

  // An accepted beat always starts a walk on the next cycle.
  a_accept_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_WALK_START && phase_r == 1'b0))
    else $error("accepted beat did not start a walk");

  // A result taken with no new one pending leaves the output empty.
  a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && state_r != S_DONE) |=> !out_valid_r)
    else $error("output stayed valid after its beat was taken");

endmodule
